// ===== rtl/core/snrf_pkg.sv =====
`default_nettype none
package snrf_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int TOL_WIDTH      = 31;
   localparam int ITER_WIDTH     = 8;
   localparam int KIND_WIDTH     = 3;
   localparam int CSR_ADDR_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 31;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_TOLERANCE      = 1'b0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_MAX_ITERATIONS = 1'b1;

   localparam logic [TOL_WIDTH-1:0]  TOL_RESET  = 31'd66;
   localparam logic [ITER_WIDTH-1:0] ITER_RESET = 8'd100;

   localparam logic OP_START = 1'b0;
   localparam logic OP_REPLY = 1'b1;

   localparam logic [KIND_WIDTH-1:0] KIND_EVAL    = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_ROOT    = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_NOBRK   = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_LIMIT   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_IGNORED = 3'd4;

   typedef struct packed {
      logic               op;
      logic signed [31:0] bound_a;
      logic signed [31:0] bound_b;
      logic signed [31:0] f_value;
      logic signed [31:0] slope;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] point;
      logic [7:0]         iterations;
   } rsp_word_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_WAIT_A, PH_WAIT_B, PH_ITER
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_MUL1, ST_MUL2, ST_CMP, ST_DIV, ST_FINISH, ST_OUT
   } ctl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture input word
      logic decode;     // handle start / wait phases and iteration bookkeeping, may finish
      logic mul1;       // differences for side tests
      logic mul2;       // products for side tests and slow-convergence test
      logic cmp;        // decide bisect, start divider if newton
      logic div_step;   // one divider iteration
      logic finish;     // compute estimate and result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done_early; // decode produced the result
      logic need_div;   // newton step uses the divider
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/core/snrf_ctrl.sv =====
`default_nettype none
module snrf_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   input  snrf_pkg::status_type status,
   output snrf_pkg::cmd_type   cmd
);

   snrf_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= snrf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         snrf_pkg::ST_IDLE:   if (req_valid) state_in = snrf_pkg::ST_DECODE;
         snrf_pkg::ST_DECODE: state_in = status.done_early ? snrf_pkg::ST_OUT
                                                           : snrf_pkg::ST_MUL1;
         snrf_pkg::ST_MUL1:   state_in = snrf_pkg::ST_MUL2;
         snrf_pkg::ST_MUL2:   state_in = snrf_pkg::ST_CMP;
         snrf_pkg::ST_CMP:    state_in = status.need_div ? snrf_pkg::ST_DIV
                                                         : snrf_pkg::ST_FINISH;
         snrf_pkg::ST_DIV:    if (status.div_done) state_in = snrf_pkg::ST_FINISH;
         snrf_pkg::ST_FINISH: state_in = snrf_pkg::ST_OUT;
         snrf_pkg::ST_OUT:    if (!rsp_stall) state_in = snrf_pkg::ST_IDLE;
         default:             state_in = snrf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != snrf_pkg::ST_IDLE);
      rsp_valid = (state_ff == snrf_pkg::ST_OUT);
      unique case (state_ff)
         snrf_pkg::ST_IDLE:   cmd.load     = req_valid;
         snrf_pkg::ST_DECODE: cmd.decode   = 1'b1;
         snrf_pkg::ST_MUL1:   cmd.mul1     = 1'b1;
         snrf_pkg::ST_MUL2:   cmd.mul2     = 1'b1;
         snrf_pkg::ST_CMP:    cmd.cmp      = 1'b1;
         snrf_pkg::ST_DIV:    cmd.div_step = 1'b1;
         snrf_pkg::ST_FINISH: cmd.finish   = 1'b1;
         default:             ;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/snrf_dp.sv =====
`default_nettype none
module snrf_dp #(
   parameter int DATA_WIDTH = snrf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = snrf_pkg::FRAC_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  snrf_pkg::cmd_type            cmd,
   output snrf_pkg::status_type         status,
   input  snrf_pkg::req_word_type       req_word,
   input  wire [snrf_pkg::TOL_WIDTH-1:0]  tolerance,
   input  wire [snrf_pkg::ITER_WIDTH-1:0] max_iterations,
   output snrf_pkg::rsp_word_type       rsp_word
);

   localparam int W   = DATA_WIDTH;
   localparam int PW  = 2 * W + 2;
   localparam int DNW = W + FRAC_BITS + 1;
   localparam int DCW = $clog2(DNW + 1);
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   snrf_pkg::phase_type phase_ff;
   logic signed [W-1:0] end_a_ff, end_b_ff, fa_ff, neg_ff, pos_ff, est_ff;
   logic signed [W-1:0] step_ff, prev_ff;
   logic [snrf_pkg::ITER_WIDTH-1:0] cnt_ff;
   logic op_ff;
   logic signed [W-1:0] f_ff, df_ff;
   logic signed [W:0]   dpos_ff, dneg_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic [PW-1:0] slow_ff;
   logic bisect_ff;
   logic [DNW-1:0] rem_ff, quo_ff, dvs_ff;
   logic [DCW-1:0] dcnt_ff;
   logic qneg_ff;
   snrf_pkg::rsp_word_type rsp_ff;

   function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
      if (v > $signed({{3{1'b0}}, MAXV[W-2:0]})) sat_w = MAXV;
      else if (v < $signed({{3{1'b1}}, MINV[W-2:0]})) sat_w = MINV;
      else sat_w = v[W-1:0];
   endfunction

   logic signed [W-1:0] in_a, in_b, in_f, in_df;
   assign in_a  = req_word.bound_a[W-1:0];
   assign in_b  = req_word.bound_b[W-1:0];
   assign in_f  = req_word.f_value[W-1:0];
   assign in_df = req_word.slope[W-1:0];

   logic signed [W:0] diff_ba, sum_ab, mid;
   logic [W:0] diff_mag;
   logic signed [W-1:0] init_step;
   assign diff_ba   = {end_b_ff[W-1], end_b_ff} - {end_a_ff[W-1], end_a_ff};
   assign sum_ab    = {end_a_ff[W-1], end_a_ff} + {end_b_ff[W-1], end_b_ff};
   assign mid       = (sum_ab + {{W{1'b0}}, sum_ab[W]}) >>> 1;
   assign diff_mag  = diff_ba[W] ? -diff_ba : diff_ba;
   assign init_step = (diff_mag[W:W-1] != 2'b00) ? MAXV : diff_mag[W-1:0];

   logic signed [PW-1:0] fscaled;
   assign fscaled = PW'(f_ff) <<< FRAC_BITS;

   logic [W-1:0] f_mag, df_mag, prev_mag;
   assign f_mag    = f_ff[W-1] ? W'(-f_ff) : W'(f_ff);
   assign df_mag   = df_ff[W-1] ? W'(-df_ff) : W'(df_ff);
   assign prev_mag = prev_ff[W-1] ? W'(-prev_ff) : W'(prev_ff);

   logic sgn_pos_gt, sgn_pos_lt, sgn_neg_gt, sgn_neg_lt, bis_side;
   assign sgn_pos_gt = p1_ff > fscaled;
   assign sgn_pos_lt = p1_ff < fscaled;
   assign sgn_neg_gt = p2_ff > fscaled;
   assign sgn_neg_lt = p2_ff < fscaled;
   assign bis_side = !((sgn_pos_gt && sgn_neg_lt) || (sgn_pos_lt && sgn_neg_gt));

   logic [PW-1:0] f_sh;
   assign f_sh = PW'(f_mag) << (FRAC_BITS + 1);

   // bisection
   logic signed [W:0] pn_diff, half;
   logic signed [W-1:0] bis_est;
   assign pn_diff = {pos_ff[W-1], pos_ff} - {neg_ff[W-1], neg_ff};
   assign half    = (pn_diff + {{W{1'b0}}, pn_diff[W]}) >>> 1;
   assign bis_est = W'({neg_ff[W-1], neg_ff} + half);

   // divider result
   logic signed [DNW:0] q_signed;
   logic signed [W-1:0] newton_step, newton_est, next_step, next_est;
   assign q_signed = qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   always_comb begin
      if (df_ff == '0) begin
         newton_step = f_ff[W-1] ? MINV : ((f_ff == '0) ? '0 : MAXV);
      end else if (q_signed > $signed((DNW+1)'(MAXV))) begin
         newton_step = MAXV;
      end else if (q_signed < -$signed((DNW+1)'({1'b0, MINV}))) begin
         newton_step = MINV;
      end else begin
         newton_step = q_signed[W-1:0];
      end
   end
   assign newton_est = sat_w({{2{est_ff[W-1]}}, est_ff} - {{2{newton_step[W-1]}}, newton_step});
   assign next_step  = bisect_ff ? half[W-1:0] : newton_step;
   assign next_est   = bisect_ff ? bis_est : newton_est;

   logic [W-1:0] step_mag;
   assign step_mag = next_step[W-1] ? W'(-next_step) : W'(next_step);
   logic tol_hit;
   assign tol_hit = {1'b0, step_mag} < ($bits(step_mag)+1)'(tolerance);

   logic [DNW-1:0] rem_sh;
   logic [DNW:0]   rem_sub;
   assign rem_sh  = {rem_ff[DNW-2:0], quo_ff[DNW-1]};
   assign rem_sub = {1'b0, rem_sh} - {1'b0, dvs_ff};

   // only an iteration reply under the limit goes on past decode
   assign status.done_early = !(op_ff == snrf_pkg::OP_REPLY &&
                                phase_ff == snrf_pkg::PH_ITER &&
                                cnt_ff < max_iterations);
   assign status.need_div   = !bis_side && !(f_sh > slow_ff);
   assign status.div_done   = (dcnt_ff == '0);
   assign rsp_word          = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= snrf_pkg::PH_IDLE;
         cnt_ff   <= '0;
         end_a_ff <= '0; end_b_ff <= '0; fa_ff <= '0;
         neg_ff   <= '0; pos_ff <= '0; est_ff <= '0;
         step_ff  <= '0; prev_ff <= '0;
      end else begin
         if (cmd.load) begin
            op_ff <= req_word.op;
            f_ff  <= in_f;
            df_ff <= in_df;
            if (req_word.op == snrf_pkg::OP_START) begin
               end_a_ff <= in_a;
               end_b_ff <= in_b;
            end
         end
         if (cmd.decode) begin
            if (op_ff == snrf_pkg::OP_START) begin
               cnt_ff   <= '0;
               phase_ff <= snrf_pkg::PH_WAIT_A;
               rsp_ff   <= '{kind: snrf_pkg::KIND_EVAL, point: 32'(end_a_ff),
                             iterations: '0};
            end else begin
               unique case (phase_ff)
                  snrf_pkg::PH_WAIT_A: begin
                     if (f_ff == '0) begin
                        phase_ff <= snrf_pkg::PH_IDLE;
                        rsp_ff   <= '{kind: snrf_pkg::KIND_ROOT, point: 32'(end_a_ff),
                                      iterations: '0};
                     end else begin
                        fa_ff    <= f_ff;
                        phase_ff <= snrf_pkg::PH_WAIT_B;
                        rsp_ff   <= '{kind: snrf_pkg::KIND_EVAL, point: 32'(end_b_ff),
                                      iterations: '0};
                     end
                  end
                  snrf_pkg::PH_WAIT_B: begin
                     if (f_ff == '0) begin
                        phase_ff <= snrf_pkg::PH_IDLE;
                        rsp_ff   <= '{kind: snrf_pkg::KIND_ROOT, point: 32'(end_b_ff),
                                      iterations: '0};
                     end else if ((fa_ff > 0) == (f_ff > 0)) begin
                        phase_ff <= snrf_pkg::PH_IDLE;
                        rsp_ff   <= '{kind: snrf_pkg::KIND_NOBRK, point: '0,
                                      iterations: '0};
                     end else begin
                        if (fa_ff[W-1]) begin
                           neg_ff <= end_a_ff; pos_ff <= end_b_ff;
                        end else begin
                           pos_ff <= end_a_ff; neg_ff <= end_b_ff;
                        end
                        est_ff  <= mid[W-1:0];
                        prev_ff <= init_step;
                        step_ff <= init_step;
                        cnt_ff  <= '0;
                        phase_ff <= snrf_pkg::PH_ITER;
                        rsp_ff   <= '{kind: snrf_pkg::KIND_EVAL, point: 32'(mid[W-1:0]),
                                      iterations: '0};
                     end
                  end
                  snrf_pkg::PH_ITER: begin
                     if (cnt_ff != '0) begin
                        if (f_ff[W-1]) neg_ff <= est_ff;
                        else pos_ff <= est_ff;
                     end
                     if (cnt_ff >= max_iterations) begin
                        phase_ff <= snrf_pkg::PH_IDLE;
                        rsp_ff   <= '{kind: snrf_pkg::KIND_LIMIT, point: 32'(est_ff),
                                      iterations: cnt_ff};
                     end else begin
                        cnt_ff <= cnt_ff + 1'b1;
                     end
                  end
                  default: begin
                     rsp_ff <= '{kind: snrf_pkg::KIND_IGNORED, point: '0, iterations: '0};
                  end
               endcase
            end
         end
         if (cmd.mul1) begin
            dpos_ff <= {est_ff[W-1], est_ff} - {pos_ff[W-1], pos_ff};
            dneg_ff <= {est_ff[W-1], est_ff} - {neg_ff[W-1], neg_ff};
         end
         if (cmd.mul2) begin
            p1_ff   <= PW'(dpos_ff * df_ff);
            p2_ff   <= PW'(dneg_ff * df_ff);
            slow_ff <= PW'(prev_mag) * PW'(df_mag);
         end
         if (cmd.cmp) begin
            bisect_ff <= bis_side || (f_sh > slow_ff);
            prev_ff   <= step_ff;
            rem_ff    <= '0;
            quo_ff    <= DNW'(f_mag) << FRAC_BITS;
            dvs_ff    <= DNW'(df_mag);
            dcnt_ff   <= DCW'(DNW);
            qneg_ff   <= f_ff[W-1] ^ df_ff[W-1];
         end
         if (cmd.div_step && dcnt_ff != '0) begin
            dcnt_ff <= dcnt_ff - 1'b1;
            if (!rem_sub[DNW]) begin
               rem_ff <= rem_sub[DNW-1:0];
               quo_ff <= {quo_ff[DNW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[DNW-2:0], 1'b0};
            end
         end
         if (cmd.finish) begin
            step_ff <= next_step;
            est_ff  <= next_est;
            rsp_ff.point      <= 32'(next_est);
            rsp_ff.iterations <= cnt_ff;
            if ((bisect_ff && next_est == neg_ff) || (!bisect_ff && next_est == est_ff)
                || tol_hit) begin
               phase_ff <= snrf_pkg::PH_IDLE;
               rsp_ff.kind <= snrf_pkg::KIND_ROOT;
            end else begin
               rsp_ff.kind <= snrf_pkg::KIND_EVAL;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/safeguarded_newton_root_finder_core.sv =====
`default_nettype none
// Newton-bisection root finder in signed fixed point (Q16.16 by default). A start
// word (op 0) loads the bracket and is answered with the first point to evaluate;
// each reply word (op 1) carries f and f' at the requested point and is answered
// with the next point, a root, or an error kind. One word is handled at a time:
// start words, bracket-end replies, ignored replies and replies at the iteration
// limit go from decode straight to the output; iteration replies also pass the
// multiply, compare and finish states, and Newton steps wait on the restoring
// divider that forms f/f' one quotient bit a cycle.
module safeguarded_newton_root_finder_core #(
   parameter int DATA_WIDTH = snrf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = snrf_pkg::FRAC_BITS_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  snrf_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output snrf_pkg::rsp_word_type                 rsp_word,
   input  wire                                    csr_write,
   input  wire [snrf_pkg::CSR_ADDR_WIDTH-1:0]     csr_index,
   input  wire [snrf_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   logic [snrf_pkg::TOL_WIDTH-1:0]  tol_ff;
   logic [snrf_pkg::ITER_WIDTH-1:0] maxit_ff;
   snrf_pkg::cmd_type    cmd;
   snrf_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= snrf_pkg::TOL_RESET;
         maxit_ff <= snrf_pkg::ITER_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            snrf_pkg::CSR_TOLERANCE:      tol_ff   <= csr_data;
            snrf_pkg::CSR_MAX_ITERATIONS: maxit_ff <= csr_data[snrf_pkg::ITER_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   snrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   snrf_dp #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_word       (req_word),
      .tolerance      (tol_ff),
      .max_iterations (maxit_ff),
      .rsp_word       (rsp_word)
   );

endmodule
`default_nettype wire

// ===== tb/tb_safeguarded_newton_root_finder_checker.sv =====
`timescale 1ns / 1ps
module tb_safeguarded_newton_root_finder_checker (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_stall,
   input  snrf_pkg::req_word_type req_word,
   input  wire                    rsp_valid,
   input  wire                    rsp_stall,
   input  snrf_pkg::rsp_word_type rsp_word,
   input  wire                    csr_write,
   input  wire [snrf_pkg::CSR_ADDR_WIDTH-1:0] csr_index,
   input  wire [snrf_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   output int                     error_count,
   output int                     pending_count
);

   localparam longint MAXV = 64'sd2147483647;
   localparam longint MINV = -64'sd2147483648;

   snrf_pkg::rsp_word_type expected_words[$];

   logic [30:0] tol_reg;
   logic [7:0]  iter_limit;
   snrf_pkg::phase_type phase;
   longint      end_a, end_b, value_at_a, neg_side, pos_side, estimate, step_size, prev_step;
   logic [7:0]  iter_count;

   function automatic longint clamp32(longint v);
      if (v > MAXV) return MAXV;
      if (v < MINV) return MINV;
      return v;
   endfunction

   function automatic longint absval(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic int bracket_sign(longint d, longint df, longint f);
      longint p, q;
      p = d * df;
      q = f * 65536;
      return p > q ? 1 : (p < q ? -1 : 0);
   endfunction

   function automatic snrf_pkg::rsp_word_type mk(logic [2:0] k, longint p, logic [7:0] it);
      snrf_pkg::rsp_word_type w;
      w.kind = k;
      w.point = p[31:0];
      w.iterations = it;
      return w;
   endfunction

   function automatic snrf_pkg::rsp_word_type next_point(snrf_pkg::req_word_type w);
      longint f, df, old;
      logic   bisect;
      logic [127:0] lhs, rhs;
      f = longint'(w.f_value);
      df = longint'(w.slope);
      if (w.op == snrf_pkg::OP_START) begin
         end_a = longint'(w.bound_a);
         end_b = longint'(w.bound_b);
         iter_count = '0;
         phase = snrf_pkg::PH_WAIT_A;
         return mk(snrf_pkg::KIND_EVAL, end_a, 8'd0);
      end
      if (phase == snrf_pkg::PH_WAIT_A) begin
         if (f == 0) begin
            phase = snrf_pkg::PH_IDLE;
            return mk(snrf_pkg::KIND_ROOT, end_a, 8'd0);
         end
         value_at_a = f;
         phase = snrf_pkg::PH_WAIT_B;
         return mk(snrf_pkg::KIND_EVAL, end_b, 8'd0);
      end
      if (phase == snrf_pkg::PH_WAIT_B) begin
         if (f == 0) begin
            phase = snrf_pkg::PH_IDLE;
            return mk(snrf_pkg::KIND_ROOT, end_b, 8'd0);
         end
         if ((value_at_a > 0) == (f > 0)) begin
            phase = snrf_pkg::PH_IDLE;
            return mk(snrf_pkg::KIND_NOBRK, 0, 8'd0);
         end
         if (value_at_a < 0) begin
            neg_side = end_a;
            pos_side = end_b;
         end else begin
            pos_side = end_a;
            neg_side = end_b;
         end
         estimate = (end_a + end_b) / 2;
         prev_step = absval(end_b - end_a);
         if (prev_step > MAXV) prev_step = MAXV;
         step_size = prev_step;
         iter_count = '0;
         phase = snrf_pkg::PH_ITER;
         return mk(snrf_pkg::KIND_EVAL, estimate, 8'd0);
      end
      if (phase != snrf_pkg::PH_ITER) return mk(snrf_pkg::KIND_IGNORED, 0, 8'd0);
      if (iter_count > 0) begin
         if (f < 0) neg_side = estimate;
         else pos_side = estimate;
      end
      if (iter_count >= iter_limit) begin
         phase = snrf_pkg::PH_IDLE;
         return mk(snrf_pkg::KIND_LIMIT, estimate, iter_count);
      end
      iter_count = iter_count + 8'd1;
      bisect = bracket_sign(estimate - pos_side, df, f) *
               bracket_sign(estimate - neg_side, df, f) >= 0;
      lhs = 128'(absval(f)) << 17;
      rhs = 128'(absval(prev_step)) * 128'(absval(df));
      if (!bisect && lhs > rhs) bisect = 1'b1;
      prev_step = step_size;
      if (bisect) begin
         step_size = (pos_side - neg_side) / 2;
         estimate = neg_side + step_size;
         if (estimate == neg_side) begin
            phase = snrf_pkg::PH_IDLE;
            return mk(snrf_pkg::KIND_ROOT, estimate, iter_count);
         end
      end else begin
         if (df == 0) step_size = f > 0 ? MAXV : (f < 0 ? MINV : 0);
         else step_size = clamp32((f * 65536) / df);
         old = estimate;
         estimate = clamp32(estimate - step_size);
         if (estimate == old) begin
            phase = snrf_pkg::PH_IDLE;
            return mk(snrf_pkg::KIND_ROOT, estimate, iter_count);
         end
      end
      if (absval(step_size) < longint'(tol_reg)) begin
         phase = snrf_pkg::PH_IDLE;
         return mk(snrf_pkg::KIND_ROOT, estimate, iter_count);
      end
      return mk(snrf_pkg::KIND_EVAL, estimate, iter_count);
   endfunction

   assign pending_count = expected_words.size();

   always @(posedge clock) begin
      snrf_pkg::rsp_word_type exp_w;
      if (reset) begin
         tol_reg <= snrf_pkg::TOL_RESET;
         iter_limit <= snrf_pkg::ITER_RESET;
         phase = snrf_pkg::PH_IDLE;
         end_a = 0; end_b = 0; value_at_a = 0; neg_side = 0; pos_side = 0;
         estimate = 0; step_size = 0; prev_step = 0; iter_count = '0;
         expected_words.delete();
         error_count <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == snrf_pkg::CSR_TOLERANCE) tol_reg <= csr_data[30:0];
            else if (csr_index == snrf_pkg::CSR_MAX_ITERATIONS) iter_limit <= csr_data[7:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word kind=%0d point=%0d", rsp_word.kind, rsp_word.point);
               error_count <= error_count + 1;
            end else begin
               exp_w = expected_words.pop_front();
               if (exp_w !== rsp_word) begin
                  if (exp_w.kind !== rsp_word.kind)
                     $error("kind expected %0d actual %0d", exp_w.kind, rsp_word.kind);
                  if (exp_w.point !== rsp_word.point)
                     $error("point expected %0d actual %0d", exp_w.point, rsp_word.point);
                  if (exp_w.iterations !== rsp_word.iterations)
                     $error("iterations expected %0d actual %0d",
                            exp_w.iterations, rsp_word.iterations);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) expected_words.push_back(next_point(req_word));
      end
   end

endmodule

// ===== tb/tb_safeguarded_newton_root_finder_core.sv =====
`timescale 1ns / 1ps
module tb_safeguarded_newton_root_finder_core;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   snrf_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   snrf_pkg::rsp_word_type rsp_word;
   logic csr_write = 0;
   logic [snrf_pkg::CSR_ADDR_WIDTH-1:0] csr_index = '0;
   logic [snrf_pkg::CSR_DATA_WIDTH-1:0] csr_data = '0;
   int error_count, pending_count;
   int idle_cycles = 0;
   int sent = 0;
   logic calm = 0;
   logic [1:0] search_mode = 0;
   longint root_x = 0;
   longint gain = 65536;
   int target = 600;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   safeguarded_newton_root_finder_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   tb_safeguarded_newton_root_finder_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   always @(posedge clock) begin
      if (!reset) rsp_stall <= !calm && ($urandom_range(0, 99) < 15);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [31:0] rand32();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         default: return $urandom();
      endcase
   endfunction

   task automatic send(logic op, logic [31:0] a, logic [31:0] b, logic [31:0] f,
                       logic [31:0] df);
      while (!calm && $urandom_range(0, 99) < 15) @(posedge clock);
      req_valid <= 1;
      req_word <= '{op: op, bound_a: a, bound_b: b, f_value: f, slope: df};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 0;
      sent++;
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [snrf_pkg::CSR_ADDR_WIDTH-1:0] idx,
                            logic [snrf_pkg::CSR_DATA_WIDTH-1:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
   endtask

   // linear f(x) = gain*(x - root) at the asked point, at times noisy f or random slope
   task automatic answer(logic [31:0] x);
      longint f;
      f = (gain * (longint'($signed(x)) - root_x)) >>> 16;
      if ($urandom_range(0, 9) == 0) f = f + $signed($urandom_range(0, 2000)) - 1000;
      if (f > 64'sd2147483647) f = 64'sd2147483647;
      if (f < -64'sd2147483648) f = -64'sd2147483648;
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, f[31:0],
           ($urandom_range(0, 7) == 0) ? $urandom() : gain[31:0]);
   endtask

   task automatic run_search();
      longint a, b;
      snrf_pkg::rsp_word_type w;
      int guard;
      a = $signed($urandom_range(0, 2000000)) - 1000000;
      b = a + $urandom_range(1, 3000000);
      root_x = a + ((b - a) * $urandom_range(0, 100)) / 100;
      gain = longint'($urandom_range(1, 400000)) * (($urandom_range(0, 1)) ? 1 : -1);
      if ($urandom_range(0, 1)) send(snrf_pkg::OP_START, a[31:0], b[31:0], 32'd0, 32'd0);
      else send(snrf_pkg::OP_START, b[31:0], a[31:0], 32'd0, 32'd0);
      guard = 0;
      while (guard < 300 && sent < target + 40) begin
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         w = rsp_word;
         @(posedge clock);
         if (w.kind != snrf_pkg::KIND_EVAL) break;
         if ($urandom_range(0, 40) == 0) break;
         answer(w.point);
         guard++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      calm <= 1;
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h7fffffff, 32'h80000000);
      send(snrf_pkg::OP_START, 32'h80000000, 32'h7fffffff, 32'd0, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'hffff0000, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h00010000, 32'h00010000);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h00000100, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h80000000, 32'h7fffffff);
      send(snrf_pkg::OP_START, 32'h00010000, 32'h00020000, 32'd0, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'd0, 32'h1);
      send(snrf_pkg::OP_START, 32'h00010000, 32'h00020000, 32'd0, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h5, 32'h1);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'd0, 32'h1);
      send(snrf_pkg::OP_START, 32'h00010000, 32'h00020000, 32'd0, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h5, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h7, 32'd0);
      send(snrf_pkg::OP_START, 32'h0, 32'h00020000, 32'd0, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'hfffe0000, 32'h00010000);
      send(snrf_pkg::OP_START, 32'h0, 32'h00040000, 32'd0, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'hfffe0000, 32'h00010000);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h00020000, 32'h00010000);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h00000001, 32'h00010000);
      calm <= 0;
      drain();
      write_reg(snrf_pkg::CSR_MAX_ITERATIONS, '0);
      write_reg(snrf_pkg::CSR_TOLERANCE, '0);
      send(snrf_pkg::OP_START, 32'h0, 32'h00040000, 32'd0, 32'd0);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'hfffe0000, 32'h00010000);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h00020000, 32'h00010000);
      send(snrf_pkg::OP_REPLY, 32'd0, 32'd0, 32'h00000003, 32'h00010000);
      drain();
      while (sent < target) begin
         if ($urandom_range(0, 60) == 0) begin
            drain();
            search_mode = 2'($urandom_range(0, 3));
            case (search_mode)
               2'd0: write_reg(snrf_pkg::CSR_TOLERANCE, 31'h7fffffff);
               2'd1: write_reg(snrf_pkg::CSR_TOLERANCE, '0);
               default: write_reg(snrf_pkg::CSR_TOLERANCE, 31'($urandom_range(0, 5000)));
            endcase
            write_reg(snrf_pkg::CSR_MAX_ITERATIONS,
                      31'(($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 30)));
         end
         calm <= (sent > 250 && sent < 350);
         if ($urandom_range(0, 9) == 0)
            send(1'($urandom_range(0, 1)), rand32(), rand32(), rand32(), rand32());
         else run_search();
      end
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
